// ===== design/hcm_pkg.sv =====
// Shared types, constants and mod-26 helpers for the 3x3 Hill cipher block.
`default_nettype none

package hcm_pkg;

    typedef logic [4:0]      t_letter;
    typedef t_letter [8:0]   t_mat;      // entry r,c at index 3r+c
    typedef t_letter [2:0]   t_block;    // letter i of a block at index i

    localparam t_letter     MODULUS     = 5'd26;
    localparam t_letter     PAD_LETTER  = 5'd23;
    localparam logic [6:0]  RECIP       = 7'd79;    // 79/2048 just above 1/26
    localparam int          RECIP_SHIFT = 11;
    localparam logic [10:0] MOD_BIAS    = 11'd650;  // 25*26, keeps cofactors positive
    localparam t_mat        KEY_IDENT   = t_mat'(45'd1099512676353);

    // configuration register indexes
    localparam logic [1:0]  REG_KEY     = 2'd0;
    localparam logic [1:0]  REG_MODE    = 2'd1;

    // key unit -> datapath
    typedef struct packed {
        t_mat key;
        t_mat inv;
        logic invertible;
        logic decrypt;
        logic busy;
    } t_key_info;

    // reduce a 5-bit code once
    function automatic t_letter red26(input t_letter v);
        return (v >= MODULUS) ? t_letter'(v - MODULUS) : v;
    endfunction

    // remainder of an 11-bit value: reciprocal estimate is at most one too high
    function automatic t_letter mod26(input logic [10:0] v);
        logic [17:0] p;
        logic [6:0]  q;
        logic [11:0] r;
        p = 18'(v) * 18'(RECIP);
        q = p[17:RECIP_SHIFT];
        r = 12'(v) - 12'(q) * 12'(MODULUS);
        if (r[11]) begin
            r = r + 12'(MODULUS);
        end
        return r[4:0];
    endfunction

    // multiplicative inverse mod 26, zero when none exists
    function automatic t_letter inv26(input t_letter v);
        t_letter r;
        case (v)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/hcm_if.sv =====
// Valid/ready stream interfaces for letter input and cipher result output.
`default_nettype none

interface hcm_in_if;
    logic                 valid;
    logic                 ready;
    hcm_pkg::t_letter     letter;
    logic                 stream_end;

    modport source (output valid, output letter, output stream_end, input ready);
    modport sink   (input valid, input letter, input stream_end, output ready);
endinterface

interface hcm_out_if;
    logic                 valid;
    logic                 ready;
    hcm_pkg::t_letter     out_letter;
    logic                 block_last;
    logic                 key_error;

    modport source (output valid, output out_letter, output block_last, output key_error,
                    input ready);
    modport sink   (input valid, input out_letter, input block_last, input key_error,
                    output ready);
endinterface

`default_nettype wire

// ===== design/hcm_keygen.sv =====
// Key registers, mode register and the multi-cycle inverse key computation.
`default_nettype none

module hcm_keygen (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [44:0]        i_cfg_data,
    output hcm_pkg::t_key_info      o_key_info
);

    typedef enum logic [6:0] {
        KG_IDLE = 7'b0000001,
        KG_COF  = 7'b0000010,
        KG_ADJ  = 7'b0000100,
        KG_DET  = 7'b0001000,
        KG_DINV = 7'b0010000,
        KG_PROD = 7'b0100000,
        KG_INV  = 7'b1000000
    } t_kg_state;

    t_kg_state              r_state, n_state;
    hcm_pkg::t_mat          r_key;
    hcm_pkg::t_mat          r_inv;
    logic                   r_invertible;
    logic                   r_decrypt;
    logic [8:0][10:0]       r_cof;      // biased cofactors, then adj*dinv products
    hcm_pkg::t_mat          r_adj;
    logic [10:0]            r_det;
    hcm_pkg::t_letter       r_dinv;

    hcm_pkg::t_mat          w_key_in;

    // 2x2 minor with bias so the difference stays non-negative
    function automatic logic [10:0] cof(input hcm_pkg::t_letter a, input hcm_pkg::t_letter b,
                                        input hcm_pkg::t_letter c, input hcm_pkg::t_letter d);
        logic [9:0] p;
        logic [9:0] q;
        p = 10'(a) * 10'(b);
        q = 10'(c) * 10'(d);
        return 11'(p) + hcm_pkg::MOD_BIAS - 11'(q);
    endfunction

    // written key entries reduced mod 26
    always_comb begin
        w_key_in = hcm_pkg::t_mat'(i_cfg_data);
        for (int e = 0; e < 9; e++) begin
            w_key_in[e] = hcm_pkg::red26(w_key_in[e]);
        end
    end

    // sequencer
    always_comb begin
        case (r_state)
            KG_IDLE: n_state = (i_cfg_we && i_cfg_idx == hcm_pkg::REG_KEY) ? KG_COF : KG_IDLE;
            KG_COF:  n_state = KG_ADJ;
            KG_ADJ:  n_state = KG_DET;
            KG_DET:  n_state = KG_DINV;
            KG_DINV: n_state = KG_PROD;
            KG_PROD: n_state = KG_INV;
            KG_INV:  n_state = KG_IDLE;
            default: n_state = KG_IDLE;
        endcase
    end

    // control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= KG_IDLE;
            r_key        <= hcm_pkg::KEY_IDENT;
            r_inv        <= hcm_pkg::KEY_IDENT;
            r_invertible <= 1'b1;
            r_decrypt    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx == hcm_pkg::REG_KEY) begin
                r_key <= w_key_in;
            end
            if (i_cfg_we && i_cfg_idx == hcm_pkg::REG_MODE) begin
                r_decrypt <= i_cfg_data[0];
            end
            if (r_state == KG_INV) begin
                r_invertible <= (r_dinv != '0);
                for (int e = 0; e < 9; e++) begin
                    r_inv[e] <= (r_dinv != '0) ? hcm_pkg::mod26(r_cof[e]) : '0;
                end
            end
        end
    end

    // datapath of the inverse computation
    always_ff @(posedge i_clk) begin
        case (r_state)
            KG_COF: begin
                r_cof[0] <= cof(r_key[4], r_key[8], r_key[5], r_key[7]);
                r_cof[1] <= cof(r_key[2], r_key[7], r_key[1], r_key[8]);
                r_cof[2] <= cof(r_key[1], r_key[5], r_key[2], r_key[4]);
                r_cof[3] <= cof(r_key[5], r_key[6], r_key[3], r_key[8]);
                r_cof[4] <= cof(r_key[0], r_key[8], r_key[2], r_key[6]);
                r_cof[5] <= cof(r_key[2], r_key[3], r_key[0], r_key[5]);
                r_cof[6] <= cof(r_key[3], r_key[7], r_key[4], r_key[6]);
                r_cof[7] <= cof(r_key[1], r_key[6], r_key[0], r_key[7]);
                r_cof[8] <= cof(r_key[0], r_key[4], r_key[1], r_key[3]);
            end
            KG_ADJ: begin
                for (int e = 0; e < 9; e++) begin
                    r_adj[e] <= hcm_pkg::mod26(r_cof[e]);
                end
            end
            KG_DET: begin
                // first row times first adjugate column
                r_det <= 11'(10'(r_key[0]) * 10'(r_adj[0]))
                       + 11'(10'(r_key[1]) * 10'(r_adj[3]))
                       + 11'(10'(r_key[2]) * 10'(r_adj[6]));
            end
            KG_DINV: begin
                r_dinv <= hcm_pkg::inv26(hcm_pkg::mod26(r_det));
            end
            KG_PROD: begin
                for (int e = 0; e < 9; e++) begin
                    r_cof[e] <= 11'(10'(r_adj[e]) * 10'(r_dinv));
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key_info.key        = r_key;
    assign o_key_info.inv        = r_inv;
    assign o_key_info.invertible = r_invertible;
    assign o_key_info.decrypt    = r_decrypt;
    assign o_key_info.busy       = (r_state != KG_IDLE);

endmodule

`default_nettype wire

// ===== design/hcm_front.sv =====
// Front end: takes letters, gathers blocks of three, pads short final blocks.
`default_nettype none

module hcm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    hcm_in_if.sink              i_in,
    input  wire logic           i_busy,
    input  wire logic           i_q_full,
    output logic                o_push,
    output hcm_pkg::t_block     o_block
);

    logic [1:0]                 r_cnt, n_cnt;
    hcm_pkg::t_letter [1:0]     r_held;
    hcm_pkg::t_letter           w_letter;
    logic                       w_accept;
    logic                       w_complete;

    assign i_in.ready = !i_busy && !i_q_full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_letter   = hcm_pkg::red26(i_in.letter);
    assign w_complete = (r_cnt == 2'd2) || i_in.stream_end;

    // block assembly with padding
    always_comb begin
        case (r_cnt)
            2'd0:    o_block = {hcm_pkg::PAD_LETTER, hcm_pkg::PAD_LETTER, w_letter};
            2'd1:    o_block = {hcm_pkg::PAD_LETTER, w_letter, r_held[0]};
            default: o_block = {w_letter, r_held[1], r_held[0]};
        endcase
    end

    assign o_push = w_accept && w_complete;
    assign n_cnt  = w_complete ? 2'd0 : r_cnt + 2'd1;

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_accept) begin
            r_cnt <= n_cnt;
        end
    end

    // held letters
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_complete) begin
            r_held[r_cnt[0]] <= w_letter;
        end
    end

endmodule

`default_nettype wire

// ===== design/hcm_queue.sv =====
// Two-entry block queue between the front end and the matrix back end.
`default_nettype none

module hcm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hcm_pkg::t_block i_block,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output hcm_pkg::t_block     o_block
);

    hcm_pkg::t_block [1:0]      r_mem;
    logic                       r_wp;
    logic                       r_rp;
    logic [1:0]                 r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_block = r_mem[r_rp];

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_block;
        end
    end

endmodule

`default_nettype wire

// ===== design/hcm_back.sv =====
// Back end: one matrix row per cycle unless the output stalls, sum stage then mod-26 output register.
`default_nettype none

module hcm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hcm_pkg::t_key_info i_key_info,
    input  wire logic           i_q_valid,
    input  wire hcm_pkg::t_block i_q_block,
    output logic                o_q_pop,
    hcm_out_if.source           o_out
);

    logic [1:0]                 r_row;
    logic                       r_s1_valid;
    logic [10:0]                r_s1_sum;
    logic                       r_s1_last;
    logic                       r_s1_err;
    logic                       r_o_valid;
    hcm_pkg::t_letter           r_o_letter;
    logic                       r_o_last;
    logic                       r_o_err;

    logic                       w_out_adv;
    logic                       w_s1_adv;
    logic                       w_take;
    hcm_pkg::t_mat              w_mat;
    hcm_pkg::t_letter [2:0]     w_coef;
    logic [10:0]                w_sum;

    assign w_out_adv = !r_o_valid || o_out.ready;
    assign w_s1_adv  = !r_s1_valid || w_out_adv;
    assign w_take    = i_q_valid && w_s1_adv;
    assign o_q_pop   = w_take && (r_row == 2'd2);

    // row selection from key or inverse key
    assign w_mat = i_key_info.decrypt ? i_key_info.inv : i_key_info.key;
    always_comb begin
        case (r_row)
            2'd0:    w_coef = {w_mat[2], w_mat[1], w_mat[0]};
            2'd1:    w_coef = {w_mat[5], w_mat[4], w_mat[3]};
            default: w_coef = {w_mat[8], w_mat[7], w_mat[6]};
        endcase
    end

    assign w_sum = 11'(10'(w_coef[0]) * 10'(i_q_block[0]))
                 + 11'(10'(w_coef[1]) * 10'(i_q_block[1]))
                 + 11'(10'(w_coef[2]) * 10'(i_q_block[2]));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= 2'd0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_row <= (r_row == 2'd2) ? 2'd0 : r_row + 2'd1;
            end
            if (w_s1_adv) begin
                r_s1_valid <= i_q_valid;
            end
            if (w_out_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s1_sum  <= w_sum;
            r_s1_last <= (r_row == 2'd2);
            r_s1_err  <= i_key_info.decrypt && !i_key_info.invertible;
        end
        if (w_out_adv) begin
            r_o_letter <= r_s1_err ? '0 : hcm_pkg::mod26(r_s1_sum);
            r_o_last   <= r_s1_last;
            r_o_err    <= r_s1_err;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.out_letter = r_o_letter;
    assign o_out.block_last = r_o_last;
    assign o_out.key_error  = r_o_err;

endmodule

`default_nettype wire

// ===== design/hill_cipher_3x3_mod26.sv =====
// Top level of the 3x3 Hill cipher over the 26-letter alphabet.
// Input channel i_in carries one letter code per item plus stream_end; every
// third letter (or a letter with stream_end) completes a block, padded with
// 'x' when short. Output channel o_out carries three items per block, the
// third with block_last set. key_error marks blocks decrypted with a key that
// has no inverse mod 26; their letters are zero.
// Throughput: one letter per cycle in while i_in.ready is high and one result
// per cycle out while the receiver is ready; a padded final block puts three
// results behind one letter and the two-block queue absorbs that. First result
// of a block passes the queue, the row sum stage and the mod-26 output register.
// A receiver stall holds the output register, then the sum stage, then the
// queue; i_in.ready drops when the queue is full.
// Writing the key (index 0) starts the inverse key computation during
// which i_in.ready is low. Index 1 selects decrypt. Configure only when idle.
// Reset clears the gather count, the queue and the pipeline, restores the
// identity key and selects encrypt.
`default_nettype none

module hill_cipher_3x3_mod26 (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [44:0]    i_cfg_data,
    hcm_in_if.sink              i_in,
    hcm_out_if.source           o_out
);

    hcm_pkg::t_key_info         w_key_info;
    logic                       w_push;
    hcm_pkg::t_block            w_push_block;
    logic                       w_q_full;
    logic                       w_q_valid;
    hcm_pkg::t_block            w_q_block;
    logic                       w_q_pop;

    hcm_keygen u_keygen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_key_info (w_key_info)
    );

    hcm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_busy   (w_key_info.busy),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_block  (w_push_block)
    );

    hcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_block (w_push_block),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_block (w_q_block)
    );

    hcm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_info (w_key_info),
        .i_q_valid  (w_q_valid),
        .i_q_block  (w_q_block),
        .o_q_pop    (w_q_pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
